[rtl/ltfu_pkg.sv]
// ----------------------------------------------------------------------------
// Logical time unit package
// Commands, error codes and binary64 helper functions shared by the block.
// ----------------------------------------------------------------------------
package ltfu_pkg;

  localparam logic [63:0] MagMask = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] ExpAll  = 64'h7ff0_0000_0000_0000;
  localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    CMD_SET = 2'd0,
    CMD_ADD = 2'd1,
    CMD_SUB = 2'd2,
    CMD_CMP = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_INTERVAL = 3'd1,
    ERR_TIME     = 3'd2,
    ERR_RESULT   = 3'd3,
    ERR_COMPARE  = 3'd4
  } err_e;

  // True when the pattern is a NaN.
  function automatic logic is_nan(input logic [63:0] b);
    return (b & MagMask) > ExpAll;
  endfunction

  // Ordered less-than of two non-NaN values; signed zeros compare equal.
  function automatic logic fp_less(input logic [63:0] x, input logic [63:0] y);
    logic both_zero;
    both_zero = (x[62:0] == 63'd0) && (y[62:0] == 63'd0);
    if (both_zero) return 1'b0;
    if (x[63] != y[63]) return x[63];
    if (!x[63]) return x[62:0] < y[62:0];
    return x[62:0] > y[62:0];
  endfunction

  // Next representable value toward +inf (up) or -inf (down).
  function automatic logic [63:0] neighbour(input logic [63:0] b, input logic up);
    logic neg;
    neg = b[63];
    if (b[62:0] == 63'd0) return up ? 64'd1 : (SignBit | 64'd1);
    if (b[62:0] == ExpAll[62:0] && neg != up) return b;
    if (neg == up) return b - 64'd1;
    return b + 64'd1;
  endfunction

  // Leading zero count of a 56-bit word; 56 when the word is zero.
  function automatic logic [5:0] lzc56(input logic [55:0] v);
    logic [5:0] n;
    logic       hit;
    n   = 6'd56;
    hit = 1'b0;
    for (int i = 55; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 6'(55 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

[rtl/ltfu_if.sv]
// ----------------------------------------------------------------------------
// Logical time unit channels
// Command channel and result channel, each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ltfu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] operand;

  modport source (output valid, command, operand, input ready);
  modport sink (input valid, command, operand, output ready);
endinterface

interface ltfu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] time_bits;
  logic [2:0]  error_code;
  logic        greater;
  logic        less;
  logic        equal;
  logic        is_initial;
  logic        is_final;

  modport source (output valid, time_bits, error_code, greater, less, equal,
                  is_initial, is_final, input ready);
  modport sink (input valid, time_bits, error_code, greater, less, equal,
                is_initial, is_final, output ready);
endinterface

[rtl/ltfu_adder.sv]
// ----------------------------------------------------------------------------
// Logical time adder
// Binary64 add with round-to-nearest-even, followed by a one-ulp minimum step
// in the direction of motion. Neither input may be a NaN; the interval is
// nonzero.
// ----------------------------------------------------------------------------
module ltfu_adder import ltfu_pkg::*; (
  input  logic [63:0] time_i,
  input  logic [63:0] interval_i,
  input  logic        sub_i,
  output logic [63:0] result_o,
  output logic        nan_o
);

  logic         sb, a_inf, b_inf, swap, eff_sub, g, rs, inc, ovf, up;
  logic [63:0]  bm, lg, sm, sum, nx;
  logic [10:0]  e_lg, e_sm, d, lim;
  logic [52:0]  m_lg, m_sm;
  logic [5:0]   dd, lz, shl;
  logic [119:0] shv;
  logic [55:0]  sm_al, big, mn;
  logic [56:0]  s;
  logic [11:0]  en, efield;
  logic [62:0]  rounded;

  // Operand order by magnitude and alignment of the smaller one.
  always_comb begin
    sb    = interval_i[63] ^ sub_i;
    bm    = {sb, interval_i[62:0]};
    a_inf = time_i[62:0] == ExpAll[62:0];
    b_inf = bm[62:0] == ExpAll[62:0];
    swap  = bm[62:0] > time_i[62:0];
    lg    = swap ? bm : time_i;
    sm    = swap ? time_i : bm;
    e_lg  = (lg[62:52] == 11'd0) ? 11'd1 : lg[62:52];
    e_sm  = (sm[62:52] == 11'd0) ? 11'd1 : sm[62:52];
    m_lg  = {|lg[62:52], lg[51:0]};
    m_sm  = {|sm[62:52], sm[51:0]};
    d     = e_lg - e_sm;
    dd    = (d > 11'd63) ? 6'd63 : d[5:0];
    shv   = {m_sm, 3'b000, 64'd0} >> dd;
    sm_al = {shv[119:65], shv[64] | (|shv[63:0])};
    big   = {m_lg, 3'b000};
    eff_sub = lg[63] ^ sm[63];
    s = eff_sub ? ({1'b0, big} - {1'b0, sm_al}) : ({1'b0, big} + {1'b0, sm_al});
  end

  // Normalization, subnormal limit and rounding.
  always_comb begin
    lz  = lzc56(s[55:0]);
    lim = e_lg - 11'd1;
    shl = ({5'd0, lz} > lim) ? lim[5:0] : lz;
    if (s[56]) begin
      mn = {s[56:2], s[1] | s[0]};
      en = {1'b0, e_lg} + 12'd1;
    end else begin
      mn = s[55:0] << shl;
      en = {1'b0, e_lg} - {6'd0, shl};
    end
    efield  = mn[55] ? en : 12'd0;
    g       = mn[2];
    rs      = |mn[1:0];
    inc     = g & (rs | mn[3]);
    ovf     = efield >= 12'd2047;
    rounded = {efield[10:0], mn[54:3]} + {62'd0, inc};
  end

  // Special operands, then the minimum step toward the direction of motion.
  always_comb begin
    nan_o = 1'b0;
    if (a_inf || b_inf) begin
      nan_o = a_inf && b_inf && (time_i[63] != sb);
      sum   = a_inf ? time_i : bm;
    end else if (s == 57'd0) begin
      sum = 64'd0;
    end else if (ovf) begin
      sum = {lg[63], ExpAll[62:0]};
    end else begin
      sum = {lg[63], rounded};
    end
    up = !sb;
    nx = neighbour(time_i, up);
    if (up) result_o = fp_less(sum, nx) ? nx : sum;
    else    result_o = fp_less(nx, sum) ? nx : sum;
  end

endmodule

[rtl/logical_time_float64_unit.sv]
// ----------------------------------------------------------------------------
// Logical time unit
// Holds one binary64 logical time and applies set, add, subtract and compare.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on in_i (command, operand) and each produces exactly one
//   item on out_o: the time after the step, an error code, the compare flags
//   and the initial/final status of the time.
//   An accepted item is registered, then processed in one pass of the adder
//   against the time register; the time register and the result register
//   load together, and out_o.valid rises as they load.
//   Throughput is one item per cycle unless out_o stalls: the time register is
//   written at the edge that frees the input register; the next item sees it.
//   The critical path is the binary64 align, add, normalize and round pass.
//   When out_o.ready is low the result register holds its item; the input
//   register still takes one more item if it is empty, then in_i.ready drops.
//   Reset clears both valid flags and sets the time to +0.0.
// ----------------------------------------------------------------------------
module logical_time_float64_unit import ltfu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ltfu_in_if.sink    in_i,
  ltfu_out_if.source out_o
);

  logic        in_valid_q, out_valid_q, adv, add_nan;
  logic [1:0]  cmd_q;
  logic [63:0] opd_q, time_q, time_d, add_res;
  err_e        err_d;
  logic        gt_d, lt_d, eq_d;
  logic [2:0]  err_q;
  logic        gt_q, lt_q, eq_q, init_q, fin_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || adv;

  ltfu_adder u_adder (
    .time_i     (time_q),
    .interval_i (opd_q),
    .sub_i      (cmd_q == CMD_SUB),
    .result_o   (add_res),
    .nan_o      (add_nan)
  );

  // Step decode against the current time.
  always_comb begin
    time_d = time_q;
    err_d  = ERR_OK;
    gt_d   = 1'b0;
    lt_d   = 1'b0;
    eq_d   = 1'b0;
    case (cmd_e'(cmd_q))
      CMD_SET: time_d = opd_q;
      CMD_ADD, CMD_SUB: begin
        if (is_nan(opd_q)) err_d = ERR_INTERVAL;
        else if (is_nan(time_q)) err_d = ERR_TIME;
        else if (opd_q[62:0] == 63'd0) time_d = time_q;
        else if (add_nan) err_d = ERR_RESULT;
        else time_d = add_res;
      end
      CMD_CMP: begin
        if (is_nan(time_q) || is_nan(opd_q)) begin
          err_d = ERR_COMPARE;
        end else begin
          gt_d = fp_less(opd_q, time_q);
          lt_d = fp_less(time_q, opd_q);
          eq_d = !gt_d && !lt_d;
        end
      end
      default: time_d = time_q;
    endcase
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q <= in_i.command;
      opd_q <= in_i.operand;
    end
  end

  // Time register and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      time_q      <= 64'd0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) time_q <= time_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (adv && in_valid_q) begin
      err_q  <= err_d;
      gt_q   <= gt_d;
      lt_q   <= lt_d;
      eq_q   <= eq_d;
      init_q <= time_d[62:0] == 63'd0;
      fin_q  <= time_d == ExpAll;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.time_bits  = time_q;
  assign out_o.error_code = err_q;
  assign out_o.greater    = gt_q;
  assign out_o.less       = lt_q;
  assign out_o.equal      = eq_q;
  assign out_o.is_initial = init_q;
  assign out_o.is_final   = fin_q;

endmodule
